>>> rtl/pseudocolor_colormap_lookup_unit_macros.svh
// ----------------------------------------------------------------------------
// Colormap lookup assertion macros
// Shared concurrent assertion forms for the colormap lookup unit.
// ----------------------------------------------------------------------------
`ifndef PSEUDOCOLOR_COLORMAP_LOOKUP_UNIT_MACROS_SVH
`define PSEUDOCOLOR_COLORMAP_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCCL_ASSERT_SAME(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pccl: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCCL_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pccl: next-cycle check failed");

`endif

>>> rtl/pccl_pkg.sv
// ----------------------------------------------------------------------------
// Colormap lookup package
// Map codes, channel coefficient types and anchor color tables.
// ----------------------------------------------------------------------------
package pccl_pkg;

  localparam int LEVEL_W    = 18;
  localparam int CH_W       = 8;
  localparam int CH_N       = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [2:0] map_sel_t;

  localparam map_sel_t MAP_VIRIDIS  = 3'd0;
  localparam map_sel_t MAP_PLASMA   = 3'd1;
  localparam map_sel_t MAP_COOLWARM = 3'd2;
  localparam map_sel_t MAP_GRAY     = 3'd3;
  localparam map_sel_t MAP_HOT      = 3'd4;
  localparam map_sel_t MAP_JET      = 3'd5;

  // register index, taken from paddr above the byte offset
  localparam logic [0:0] REG_MAP_SELECT = 1'b0;

  // one channel of a segment: value = base + delta * t, t in [0, 1]
  typedef struct packed {
    logic [CH_W-1:0] base;
    logic [CH_W:0]   delta;  // two's complement, -255..255
  } chan_coef_t;

  // index 2 red, 1 green, 0 blue (same order as the 24-bit color word)
  typedef chan_coef_t [CH_N-1:0] pix_coef_t;

  localparam chan_coef_t CH_ZERO = '{base: 8'd0,   delta: 9'd0};
  localparam chan_coef_t CH_FULL = '{base: 8'd255, delta: 9'd0};
  localparam chan_coef_t CH_RISE = '{base: 8'd0,   delta: 9'd255};
  localparam chan_coef_t CH_FALL = '{base: 8'd255, delta: 9'h101};

  localparam logic [23:0] VIRIDIS_ANCHOR [0:4] =
    '{24'h440154, 24'h31688E, 24'h35B779, 24'hFDE725, 24'hFFFFBF};
  localparam logic [23:0] PLASMA_ANCHOR [0:3] =
    '{24'h0D0887, 24'h7E03A8, 24'hCC4778, 24'hF0F921};
  localparam logic [23:0] COOLWARM_ANCHOR [0:2] =
    '{24'h3B4CC0, 24'hBBBBBB, 24'hB40426};
  localparam logic [23:0] JET_ANCHOR [0:4] =
    '{24'h000080, 24'h0000FF, 24'h00FF00, 24'hFFFF00, 24'hFF0000};

  function automatic pix_coef_t pair_coef(logic [23:0] c1, logic [23:0] c2);
    pix_coef_t c;
    for (int ch = 0; ch < CH_N; ch++) begin
      c[ch].base  = c1[CH_W*ch +: CH_W];
      c[ch].delta = {1'b0, c2[CH_W*ch +: CH_W]} - {1'b0, c1[CH_W*ch +: CH_W]};
    end
    return c;
  endfunction

  function automatic pix_coef_t map_coef(map_sel_t m, logic [1:0] seg);
    pix_coef_t  c;
    logic [2:0] lo;
    logic [1:0] s3;
    c  = '0;
    lo = {1'b0, seg};
    s3 = (seg == 2'd3) ? 2'd2 : seg;
    case (m)
      MAP_PLASMA: begin
        c = pair_coef(PLASMA_ANCHOR[s3], PLASMA_ANCHOR[s3 + 2'd1]);
      end
      MAP_COOLWARM: begin
        if (seg[0]) begin
          c = pair_coef(COOLWARM_ANCHOR[1], COOLWARM_ANCHOR[2]);
        end else begin
          c = pair_coef(COOLWARM_ANCHOR[0], COOLWARM_ANCHOR[1]);
        end
      end
      MAP_GRAY: begin
        c = '{CH_FALL, CH_FALL, CH_FALL};
      end
      MAP_HOT: begin
        case (s3)
          2'd0:    c = '{CH_RISE, CH_ZERO, CH_ZERO};
          2'd1:    c = '{CH_FULL, CH_RISE, CH_ZERO};
          default: c = '{CH_FULL, CH_FULL, CH_RISE};
        endcase
      end
      MAP_JET: begin
        c = pair_coef(JET_ANCHOR[lo], JET_ANCHOR[lo + 3'd1]);
      end
      default: begin
        c = pair_coef(VIRIDIS_ANCHOR[lo], VIRIDIS_ANCHOR[lo + 3'd1]);
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/pccl_if.sv
// ----------------------------------------------------------------------------
// Colormap lookup stream interfaces
// Valid/ready channels for scalar samples and RGB pixels.
// ----------------------------------------------------------------------------
interface pccl_level_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pccl_pkg::LEVEL_W-1:0]  level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface pccl_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [pccl_pkg::CH_W-1:0]  red;
  logic [pccl_pkg::CH_W-1:0]  green;
  logic [pccl_pkg::CH_W-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/pccl_cfg.sv
// ----------------------------------------------------------------------------
// Colormap lookup configuration registers
// APB-style register file holding the map select.
// ----------------------------------------------------------------------------
module pccl_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pccl_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pccl_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pccl_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output pccl_pkg::map_sel_t                 map_sel
);

  pccl_pkg::map_sel_t map_sel_r;
  logic               hit_map;

  assign hit_map = (paddr[pccl_pkg::CFG_ADDR_W-1:2] == pccl_pkg::REG_MAP_SELECT);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_sel_r <= pccl_pkg::MAP_VIRIDIS;
    end else if (psel && penable && pwrite && hit_map) begin
      map_sel_r <= pwdata[$bits(pccl_pkg::map_sel_t)-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit_map) begin
      prdata = pccl_pkg::CFG_DATA_W'(map_sel_r);
    end
  end

  assign map_sel = map_sel_r;

endmodule

>>> rtl/pccl_seg.sv
// ----------------------------------------------------------------------------
// Colormap lookup front end
// Stage 1 clamps the sample, stage 2 picks the segment, its coefficients
// and the in-segment fraction.
// ----------------------------------------------------------------------------
module pccl_seg #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  pccl_level_if.sink             in_bus,
  input  pccl_pkg::map_sel_t     map_sel,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output pccl_pkg::pix_coef_t    dn_coef,
  output logic [FRAC_BITS+1:0]   dn_tq
);

  localparam int VW  = FRAC_BITS + 1;
  localparam int TQW = FRAC_BITS + 2;
  localparam longint ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic [VW-1:0] ONE_Q  = VW'(ONE);
  localparam logic [VW-1:0] HALF_Q = VW'(ONE / 2);
  localparam logic [VW-1:0] T1_Q   = VW'((33 * ONE + 50) / 100);
  localparam logic [VW-1:0] T2_Q   = VW'((66 * ONE + 50) / 100);

  logic                 s1_valid_r;
  logic [VW-1:0]        s1_v_r;
  pccl_pkg::map_sel_t   s1_map_r;
  logic                 s1_ready;
  logic [VW-1:0]        v_nxt;
  logic signed [31:0]   lvl;

  logic                 s2_valid_r;
  pccl_pkg::pix_coef_t  s2_coef_r;
  logic [TQW-1:0]       s2_tq_r;
  logic                 s2_ready;

  logic [1:0]           seg;
  logic [2:0]           qseg;
  logic [VW-1:0]        start;
  logic [VW-1:0]        d;
  logic [TQW-1:0]       tq_nxt;
  pccl_pkg::pix_coef_t  coef_nxt;

  assign s2_ready     = !s2_valid_r || dn_ready;
  assign s1_ready     = !s1_valid_r || s2_ready;
  assign in_bus.ready = s1_ready;

  // clamp to [0, 1.0]
  always_comb begin
    lvl = 32'(in_bus.level);
    if (lvl < 0) begin
      v_nxt = '0;
    end else if (lvl > 32'(ONE)) begin
      v_nxt = ONE_Q;
    end else begin
      v_nxt = VW'(lvl);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && s1_ready) begin
      s1_v_r   <= v_nxt;
      s1_map_r <= map_sel;
    end
  end

  // segment decode; a value on a split point goes to the upper segment
  always_comb begin
    seg   = 2'd0;
    start = '0;
    qseg  = s1_v_r[FRAC_BITS -: 3];
    case (s1_map_r)
      pccl_pkg::MAP_PLASMA, pccl_pkg::MAP_HOT: begin
        if (s1_v_r >= T2_Q) begin
          seg   = 2'd2;
          start = T2_Q;
        end else if (s1_v_r >= T1_Q) begin
          seg   = 2'd1;
          start = T1_Q;
        end
      end
      pccl_pkg::MAP_COOLWARM: begin
        if (s1_v_r >= HALF_Q) begin
          seg   = 2'd1;
          start = HALF_Q;
        end
      end
      pccl_pkg::MAP_GRAY: begin
        seg   = 2'd0;
        start = '0;
      end
      default: begin
        seg   = qseg[2] ? 2'd3 : qseg[1:0];
        start = {1'b0, seg, (FRAC_BITS-2)'(0)};
      end
    endcase

    d = s1_v_r - start;

    case (s1_map_r)
      pccl_pkg::MAP_PLASMA, pccl_pkg::MAP_HOT: tq_nxt = TQW'(d) + (TQW'(d) << 1);
      pccl_pkg::MAP_COOLWARM:                  tq_nxt = TQW'(d) << 1;
      pccl_pkg::MAP_GRAY:                      tq_nxt = TQW'(s1_v_r);
      default:                                 tq_nxt = TQW'(d) << 2;
    endcase

    coef_nxt = pccl_pkg::map_coef(s1_map_r, seg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_ready) begin
      s2_coef_r <= coef_nxt;
      s2_tq_r   <= tq_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_coef  = s2_coef_r;
  assign dn_tq    = s2_tq_r;

endmodule

>>> rtl/pccl_blend.sv
// ----------------------------------------------------------------------------
// Colormap lookup blend back end
// Stage 3 multiplies each channel delta by the fraction, stage 4 adds the
// base, drops the fraction bits, saturates and holds the output pixel.
// ----------------------------------------------------------------------------
module pccl_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  pccl_pkg::pix_coef_t    up_coef,
  input  logic [FRAC_BITS+1:0]   up_tq,
  pccl_pixel_if.source           out_bus
);

  localparam int PW  = FRAC_BITS + 12;
  localparam int PAD = PW - FRAC_BITS - pccl_pkg::CH_W;
  localparam int CW  = pccl_pkg::CH_W;
  localparam int N   = pccl_pkg::CH_N;

  logic                    s3_valid_r;
  logic [CW-1:0]           s3_base_r [N];
  logic signed [PW-1:0]    s3_prod_r [N];
  logic signed [PW-1:0]    prod_nxt  [N];
  logic                    s3_ready;

  logic                    out_valid_r;
  logic [CW-1:0]           pix_r   [N];
  logic [CW-1:0]           pix_nxt [N];
  logic signed [PW-1:0]    sum     [N];
  logic                    s4_ready;

  assign s4_ready = !out_valid_r || out_bus.ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign up_ready = s3_ready;

  always_comb begin
    for (int ch = 0; ch < N; ch++) begin
      prod_nxt[ch] = PW'($signed(up_coef[ch].delta)) * PW'($signed({1'b0, up_tq}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && s3_ready) begin
      for (int ch = 0; ch < N; ch++) begin
        s3_base_r[ch] <= up_coef[ch].base;
        s3_prod_r[ch] <= prod_nxt[ch];
      end
    end
  end

  // floor(sum / ONE) clipped to 0..255
  always_comb begin
    for (int ch = 0; ch < N; ch++) begin
      sum[ch] = $signed({PAD'(0), s3_base_r[ch], FRAC_BITS'(0)}) + s3_prod_r[ch];
      if (sum[ch][PW-1]) begin
        pix_nxt[ch] = '0;
      end else if (|sum[ch][PW-2:FRAC_BITS+CW]) begin
        pix_nxt[ch] = '1;
      end else begin
        pix_nxt[ch] = sum[ch][FRAC_BITS +: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s4_ready) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r && s4_ready) begin
      for (int ch = 0; ch < N; ch++) begin
        pix_r[ch] <= pix_nxt[ch];
      end
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.red   = pix_r[2];
  assign out_bus.green = pix_r[1];
  assign out_bus.blue  = pix_r[0];

endmodule

>>> rtl/pseudocolor_colormap_lookup_unit.sv
// ----------------------------------------------------------------------------
// Pseudocolor colormap lookup unit
// Maps a signed fixed-point sample to an RGB pixel through a selectable map.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : valid/ready stream of signed samples, 2^FRAC_BITS = 1.0, clamped
//             to [0, 1.0] before mapping.
//   out_bus : valid/ready stream of 8-bit red, green, blue pixels.
//   APB port: register 0 (byte address 0) is map_select: 0 viridis, 1 plasma,
//             2 coolwarm, 3 grayscale, 4 hot, 5 jet; 6 and 7 act as viridis.
//             Write it only while no beats are in flight.
// Timing: four register stages (clamp, segment decode, channel multiply,
//   add/saturate into the output register). An accepted beat moves through
//   them in that order onto out_bus. One beat per clock is sustained while
//   out_bus is ready; the per-channel multiply stage is the deepest logic.
// Stall: each stage has its own valid bit and ready term, so bubbles are
//   squeezed out and in_bus keeps accepting until all four stages hold data.
//   A stalled output beat holds its value.
// Reset: rst_n clears all stage valid bits and sets map_select to viridis.
// ----------------------------------------------------------------------------
`include "pseudocolor_colormap_lookup_unit_macros.svh"

module pseudocolor_colormap_lookup_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pccl_level_if.sink                         in_bus,
  pccl_pixel_if.source                       out_bus,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pccl_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pccl_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pccl_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  pccl_pkg::map_sel_t    map_sel;
  logic                  seg_valid;
  logic                  seg_ready;
  pccl_pkg::pix_coef_t   seg_coef;
  logic [FRAC_BITS+1:0]  seg_tq;
  logic                  cfg_map_wr;

  pccl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .map_sel (map_sel)
  );

  pccl_seg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .map_sel  (map_sel),
    .dn_valid (seg_valid),
    .dn_ready (seg_ready),
    .dn_coef  (seg_coef),
    .dn_tq    (seg_tq)
  );

  pccl_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (seg_valid),
    .up_ready (seg_ready),
    .up_coef  (seg_coef),
    .up_tq    (seg_tq),
    .out_bus  (out_bus)
  );

  assign cfg_map_wr = psel && penable && pwrite && pready &&
                      (paddr[pccl_pkg::CFG_ADDR_W-1:2] == pccl_pkg::REG_MAP_SELECT);

  // an empty output stage lets every stage advance
  `PCCL_ASSERT_SAME(a_ready_when_drained, clk, rst_n, !out_bus.valid, in_bus.ready)
  // a stalled segment beat stays put for the blend stage
  `PCCL_ASSERT_NEXT(a_seg_hold, clk, rst_n, seg_valid && !seg_ready, seg_valid)
  // a completed write to register 0 lands in map_sel
  `PCCL_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_map_wr, map_sel == $past(pwdata[2:0]))

endmodule
